// ----- rtl/mtq_pkg.sv -----
// mtq_pkg: shared types and constants for the max-tracking queue.
// Used by mtq_stack_mem, mtq_ctrl and max_tracking_queue.
package mtq_pkg;

  localparam int MTQ_DEPTH_DEF = 64;
  localparam int OCC_W         = 7;

  localparam logic REQ_PUSH = 1'b0;
  localparam logic REQ_POP  = 1'b1;

  typedef enum logic [1:0] {
    ERR_OK    = 2'd0,
    ERR_EMPTY = 2'd1,
    ERR_FULL  = 2'd2
  } mtq_err_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REFILL,
    ST_POP,
    ST_TOPRD,
    ST_DONE
  } mtq_state_t;

  // one stack entry: value and running max of itself and everything below it
  typedef struct packed {
    logic [63:0] val;
    logic [63:0] rmax;
  } mtq_entry_t;

  typedef struct packed {
    logic        req_type;
    logic [63:0] value;
  } mtq_in_t;

  typedef struct packed {
    logic [63:0]      max_value;
    logic             queue_empty;
    logic [OCC_W-1:0] occupancy;
    logic [1:0]       error_code;
  } mtq_out_t;

endpackage

// ----- rtl/max_tracking_queue.sv -----
// FIFO of unsigned 64-bit values that reports the largest value held after every
// request, built as two stacks in two single-port-pair memories. A push goes from
// idle to the done state and the result word shows in the cycle busy drops. A pop
// from a non-empty back stack passes through a pop state and a top-read state (one
// extra memory read to fetch the new back-stack top max), or skips the top-read
// state when it empties the back stack. A pop that finds the back stack empty first
// moves the whole front stack, one entry per cycle through the front memory read
// port, in a refill state; each entry moves once. Error requests go straight to the
// done state like a push. Each result word is shown on out_word with out_strobe high
// for a single cycle; there is no backpressure on the result side.
module max_tracking_queue #(
  parameter int QUEUE_DEPTH = mtq_pkg::MTQ_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  mtq_pkg::mtq_in_t  in_word,
  output logic              out_strobe,
  output mtq_pkg::mtq_out_t out_word
);
  import mtq_pkg::*;

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic          f_we, f_re, b_we, b_re;
  logic [AW-1:0] f_waddr, f_raddr, b_waddr, b_raddr;
  mtq_entry_t    f_wdata, f_rdata, b_wdata, b_rdata;

  mtq_ctrl #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .AW          (AW),
    .CW          (CW)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_word    (in_word),
    .out_strobe (out_strobe),
    .out_word   (out_word),
    .f_we       (f_we),
    .f_waddr    (f_waddr),
    .f_wdata    (f_wdata),
    .f_re       (f_re),
    .f_raddr    (f_raddr),
    .f_rdata    (f_rdata),
    .b_we       (b_we),
    .b_waddr    (b_waddr),
    .b_wdata    (b_wdata),
    .b_re       (b_re),
    .b_raddr    (b_raddr),
    .b_rdata    (b_rdata)
  );

  mtq_stack_mem #(
    .DEPTH (QUEUE_DEPTH),
    .AW    (AW)
  ) u_front_mem (
    .clk   (clk),
    .we    (f_we),
    .waddr (f_waddr),
    .wdata (f_wdata),
    .re    (f_re),
    .raddr (f_raddr),
    .rdata (f_rdata)
  );

  mtq_stack_mem #(
    .DEPTH (QUEUE_DEPTH),
    .AW    (AW)
  ) u_back_mem (
    .clk   (clk),
    .we    (b_we),
    .waddr (b_waddr),
    .wdata (b_wdata),
    .re    (b_re),
    .raddr (b_raddr),
    .rdata (b_rdata)
  );

endmodule

// ----- rtl/mtq_stack_mem.sv -----
// mtq_stack_mem: one-write, one-read synchronous memory of stack entries.
// Depends on mtq_pkg for the entry type.
module mtq_stack_mem #(
  parameter int DEPTH = mtq_pkg::MTQ_DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                clk,
  input  logic                we,
  input  logic [AW-1:0]       waddr,
  input  mtq_pkg::mtq_entry_t wdata,
  input  logic                re,
  input  logic [AW-1:0]       raddr,
  output mtq_pkg::mtq_entry_t rdata
);
  import mtq_pkg::*;

  mtq_entry_t mem [DEPTH];
  mtq_entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/mtq_ctrl.sv -----
// mtq_ctrl: request sequencer, stack counts, top-of-stack maxima and result register.
// Depends on mtq_pkg; drives the front and back stack memories.
module mtq_ctrl #(
  parameter int QUEUE_DEPTH = mtq_pkg::MTQ_DEPTH_DEF,
  parameter int AW          = $clog2(QUEUE_DEPTH),
  parameter int CW          = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  mtq_pkg::mtq_in_t    in_word,
  output logic                out_strobe,
  output mtq_pkg::mtq_out_t   out_word,
  output logic                f_we,
  output logic [AW-1:0]       f_waddr,
  output mtq_pkg::mtq_entry_t f_wdata,
  output logic                f_re,
  output logic [AW-1:0]       f_raddr,
  input  mtq_pkg::mtq_entry_t f_rdata,
  output logic                b_we,
  output logic [AW-1:0]       b_waddr,
  output mtq_pkg::mtq_entry_t b_wdata,
  output logic                b_re,
  output logic [AW-1:0]       b_raddr,
  input  mtq_pkg::mtq_entry_t b_rdata
);
  import mtq_pkg::*;

  mtq_state_t  state_r, state_nxt;
  logic [CW-1:0] fc_r, fc_nxt;
  logic [CW-1:0] bc_r, bc_nxt;
  logic [63:0] ftop_r, ftop_nxt;
  logic [63:0] btop_r, btop_nxt;
  mtq_err_t    err_r, err_nxt;
  logic        rd_vld_r, rd_vld_nxt;
  logic        out_strobe_r, out_strobe_nxt;
  mtq_out_t    out_word_r, out_word_nxt;

  logic [CW-1:0]    total;
  logic [CW-1:0]    fc_m1;
  logic [CW-1:0]    bc_m2;
  logic [CW+OCC_W-1:0] total_ext;
  logic [63:0]      fmax, bmax, push_max, move_max;

  assign total     = fc_r + bc_r;
  assign fc_m1     = fc_r - CW'(1);
  assign bc_m2     = bc_r - CW'(2);
  assign total_ext = (CW+OCC_W)'(total);
  assign fmax      = (fc_r != '0) ? ftop_r : 64'd0;
  assign bmax      = (bc_r != '0) ? btop_r : 64'd0;
  assign push_max  = (fc_r != '0 && ftop_r > in_word.value) ? ftop_r : in_word.value;
  assign move_max  = (bc_r != '0 && btop_r > f_rdata.val) ? btop_r : f_rdata.val;

  always_comb begin
    state_nxt      = state_r;
    fc_nxt         = fc_r;
    bc_nxt         = bc_r;
    ftop_nxt       = ftop_r;
    btop_nxt       = btop_r;
    err_nxt        = err_r;
    rd_vld_nxt     = 1'b0;
    out_strobe_nxt = 1'b0;
    out_word_nxt   = out_word_r;
    f_we           = 1'b0;
    f_waddr        = fc_r[AW-1:0];
    f_wdata        = '{val: in_word.value, rmax: push_max};
    f_re           = 1'b0;
    f_raddr        = fc_m1[AW-1:0];
    b_we           = 1'b0;
    b_waddr        = bc_r[AW-1:0];
    b_wdata        = '{val: f_rdata.val, rmax: move_max};
    b_re           = 1'b0;
    b_raddr        = bc_m2[AW-1:0];

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_DONE;
          err_nxt   = ERR_OK;
          if (in_word.req_type == REQ_PUSH) begin
            if (total == CW'(QUEUE_DEPTH)) begin
              err_nxt = ERR_FULL;
            end else begin
              f_we     = 1'b1;
              fc_nxt   = fc_r + CW'(1);
              ftop_nxt = push_max;
            end
          end else begin
            if (total == '0) begin
              err_nxt = ERR_EMPTY;
            end else if (bc_r == '0) begin
              state_nxt = ST_REFILL;
            end else begin
              state_nxt = ST_POP;
            end
          end
        end
      end

      // stream front top-down onto back: read one, write the previous one
      ST_REFILL: begin
        if (rd_vld_r) begin
          b_we     = 1'b1;
          bc_nxt   = bc_r + CW'(1);
          btop_nxt = move_max;
        end
        if (fc_r != '0) begin
          f_re       = 1'b1;
          fc_nxt     = fc_m1;
          rd_vld_nxt = 1'b1;
        end else if (!rd_vld_r) begin
          state_nxt = ST_POP;
        end
      end

      ST_POP: begin
        bc_nxt = bc_r - CW'(1);
        if (bc_r >= CW'(2)) begin
          b_re      = 1'b1;
          state_nxt = ST_TOPRD;
        end else begin
          state_nxt = ST_DONE;
        end
      end

      ST_TOPRD: begin
        btop_nxt  = b_rdata.rmax;
        state_nxt = ST_DONE;
      end

      ST_DONE: begin
        out_strobe_nxt         = 1'b1;
        out_word_nxt.max_value = (fmax > bmax) ? fmax : bmax;
        out_word_nxt.queue_empty = (total == '0);
        out_word_nxt.occupancy = total_ext[OCC_W-1:0];
        out_word_nxt.error_code = err_r;
        state_nxt              = ST_IDLE;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      fc_r         <= '0;
      bc_r         <= '0;
      err_r        <= ERR_OK;
      rd_vld_r     <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      fc_r         <= fc_nxt;
      bc_r         <= bc_nxt;
      err_r        <= err_nxt;
      rd_vld_r     <= rd_vld_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ftop_r     <= ftop_nxt;
    btop_r     <= btop_nxt;
    out_word_r <= out_word_nxt;
  end

  assign busy       = (state_r != ST_IDLE);
  assign out_strobe = out_strobe_r;
  assign out_word   = out_word_r;

endmodule

// ----- dv/max_tracking_queue_tb.sv -----
// max_tracking_queue_tb: self-checking bench for the max-tracking queue, with directed
// and random push/pop traffic checked against a FIFO-with-max predictor.
// Depends on mtq_pkg and max_tracking_queue.
`timescale 1ns / 1ps

module max_tracking_queue_tb;
  import mtq_pkg::*;

  localparam int DEPTH        = MTQ_DEPTH_DEF;
  localparam int N_ITEMS      = 1250;
  localparam int IDLE_PCT     = 28;
  localparam int NOIDLE_FIRST = 500;
  localparam int NOIDLE_LAST  = 720;
  localparam int STALL_LIMIT  = 4000;
  localparam int MAX_REPORTS  = 10;

  logic     clk     = 1'b0;
  logic     rst_n   = 1'b0;
  logic     start   = 1'b0;
  mtq_in_t  in_word = '0;
  logic     busy;
  logic     out_strobe;
  mtq_out_t out_word;

  mtq_in_t     req_pending[$];
  mtq_out_t    result_expected[$];
  logic [63:0] held_values[$];

  int n_accepted   = 0;
  int n_checked    = 0;
  int n_errors     = 0;
  int n_push       = 0;
  int n_pop        = 0;
  int n_full       = 0;
  int n_empty      = 0;
  int peak_occ     = 0;
  int stall_cycles = 0;

  always #10 clk = ~clk;

  max_tracking_queue #(
    .QUEUE_DEPTH(DEPTH)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_word   (in_word),
    .out_strobe(out_strobe),
    .out_word  (out_word)
  );

  // FIFO with max: applies one request and returns the word it should produce
  function automatic mtq_out_t apply_request(input mtq_in_t req);
    mtq_out_t res;
    res = '0;
    res.error_code = ERR_OK;
    if (req.req_type == REQ_PUSH) begin
      if (held_values.size() >= DEPTH) res.error_code = ERR_FULL;
      else held_values.push_back(req.value);
    end else begin
      if (held_values.size() == 0) res.error_code = ERR_EMPTY;
      else void'(held_values.pop_front());
    end
    foreach (held_values[i]) begin
      if (held_values[i] > res.max_value) res.max_value = held_values[i];
    end
    res.queue_empty = (held_values.size() == 0);
    res.occupancy   = OCC_W'(held_values.size());
    return res;
  endfunction

  task automatic add_req(input logic kind, input logic [63:0] value);
    mtq_in_t req;
    req.req_type = kind;
    req.value    = value;
    req_pending.push_back(req);
  endtask

  task automatic fill_requests();
    logic [63:0] ramp_up;
    logic [63:0] ramp_down;
    logic [63:0] v;
    int          seg;
    int          push_pct;
    ramp_up   = '0;
    ramp_down = '1;
    // directed: empty pop, extremes, refill of the back stack, drain to empty
    add_req(REQ_POP,  64'h0);
    add_req(REQ_PUSH, 64'h0);
    add_req(REQ_POP,  64'hFFFF_FFFF_FFFF_FFFF);
    add_req(REQ_PUSH, 64'hFFFF_FFFF_FFFF_FFFF);
    add_req(REQ_PUSH, 64'h1);
    add_req(REQ_PUSH, 64'h5);
    add_req(REQ_POP,  64'h0);
    add_req(REQ_PUSH, 64'h8000_0000_0000_0000);
    add_req(REQ_PUSH, 64'h3);
    add_req(REQ_POP,  64'h0);
    add_req(REQ_POP,  64'h0);
    add_req(REQ_POP,  64'h0);
    add_req(REQ_POP,  64'h0);
    add_req(REQ_POP,  64'h0);
    add_req(REQ_PUSH, 64'd10);
    add_req(REQ_PUSH, 64'd20);
    add_req(REQ_PUSH, 64'd30);
    add_req(REQ_POP,  64'h0);
    add_req(REQ_PUSH, 64'd25);
    add_req(REQ_POP,  64'h0);
    add_req(REQ_POP,  64'h0);
    add_req(REQ_POP,  64'h0);
    add_req(REQ_POP,  64'h0);
    // random: segments biased toward filling, draining or mixing
    while (req_pending.size() < N_ITEMS) begin
      seg = $urandom_range(20, 140);
      case ($urandom_range(0, 3))
        0:       push_pct = 90;
        1:       push_pct = 10;
        default: push_pct = 55;
      endcase
      repeat (seg) begin
        case ($urandom_range(0, 9))
          0:       v = '0;
          1:       v = '1;
          2, 3:    v = 64'($urandom_range(0, 255));
          4: begin
            ramp_up = ramp_up + 64'($urandom_range(1, 1000));
            v       = ramp_up;
          end
          5: begin
            ramp_down = ramp_down - 64'($urandom_range(1, 1000));
            v         = ramp_down;
          end
          default: v = {$urandom, $urandom};
        endcase
        add_req(($urandom_range(0, 99) < push_pct) ? REQ_PUSH : REQ_POP, v);
      end
    end
  endtask

  // driver: one word in flight, held until the block takes it
  always @(posedge clk) begin
    logic     offer;
    mtq_out_t res;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      offer = start && busy;
      if (start && !busy) begin
        res = apply_request(in_word);
        result_expected.push_back(res);
        n_accepted++;
        if (in_word.req_type == REQ_PUSH) n_push++;
        else n_pop++;
        if (res.error_code == ERR_FULL) n_full++;
        if (res.error_code == ERR_EMPTY) n_empty++;
        if (int'(res.occupancy) > peak_occ) peak_occ = int'(res.occupancy);
      end
      if (!offer && req_pending.size() > 0 &&
          ((n_accepted >= NOIDLE_FIRST && n_accepted < NOIDLE_LAST) ||
           $urandom_range(0, 99) >= IDLE_PCT)) begin
        in_word <= req_pending.pop_front();
        offer = 1'b1;
      end
      start <= offer;
    end
  end

  // monitor: every strobed word must match the oldest prediction
  always @(posedge clk) begin
    mtq_out_t want;
    if (rst_n && out_strobe) begin
      if (result_expected.size() == 0) begin
        n_errors++;
        if (n_errors <= MAX_REPORTS)
          $display("ERROR: result word with nothing outstanding: max=%h empty=%b occ=%0d err=%0d",
                   out_word.max_value, out_word.queue_empty, out_word.occupancy,
                   out_word.error_code);
      end else begin
        want = result_expected.pop_front();
        n_checked++;
        if (out_word.max_value !== want.max_value || out_word.queue_empty !== want.queue_empty ||
            out_word.occupancy !== want.occupancy || out_word.error_code !== want.error_code) begin
          n_errors++;
          if (n_errors <= MAX_REPORTS)
            $display("ERROR: word %0d exp max=%h empty=%b occ=%0d err=%0d, got max=%h empty=%b occ=%0d err=%0d",
                     n_checked, want.max_value, want.queue_empty, want.occupancy, want.error_code,
                     out_word.max_value, out_word.queue_empty, out_word.occupancy,
                     out_word.error_code);
        end
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_strobe) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("max_tracking_queue_tb: errors");
        $finish;
      end
    end
  end

  initial begin
    fill_requests();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    while (req_pending.size() != 0 || start) @(posedge clk);
    while (result_expected.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("%0d requests (%0d push, %0d pop), %0d full rejects, %0d empty rejects",
             n_accepted, n_push, n_pop, n_full, n_empty);
    $display("peak occupancy %0d of %0d, %0d result words checked, %0d mismatches",
             peak_occ, DEPTH, n_checked, n_errors);
    if (n_errors == 0 && result_expected.size() == 0) begin
      $display("max_tracking_queue_tb: clean");
    end else begin
      $display("max_tracking_queue_tb: errors");
    end
    $finish;
  end

endmodule
